### rtl/fpse_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the fraction table of the fixed-point exp2 and sigmoid core.
// Depends on nothing; every other file refers to it by scoped names.
package fpse_pkg;

    localparam int OPND_W = 32;
    localparam int RES_W  = 31;
    localparam int LUT_W  = 15;
    localparam int DEN_W  = 22;
    localparam int DIV_N  = 11;
    localparam int STG_N  = DIV_N + 4;

    localparam logic OP_EXP2    = 1'b0;
    localparam logic OP_SIGMOID = 1'b1;

    localparam logic signed [OPND_W-1:0] EXP_LO = 32'shF000_0000;
    localparam logic signed [OPND_W-1:0] EXP_HI = 32'sh0F00_0000;
    localparam logic signed [OPND_W-1:0] SIG_LIM_POS = 32'sd7168;
    localparam logic signed [OPND_W-1:0] SIG_LIM_NEG = -32'sd7168;
    localparam logic signed [25:0] ARG_MUL = 26'sd1477;

    localparam logic [RES_W-1:0] POW_MAX = 31'h7fff_ffff;
    localparam logic [RES_W-1:0] POW_MIN = 31'd1;
    localparam logic [RES_W-1:0] SIG_ONE = 31'd1024;
    localparam logic [DEN_W-1:0] DEN_BIAS = 22'd1024;
    localparam logic [DEN_W-1:0] REM_INIT = 22'd512;

    localparam logic [LUT_W-1:0] FRAC_LUT [32] = '{
        15'd16562, 15'd16925, 15'd17295, 15'd17674, 15'd18061, 15'd18456, 15'd18861, 15'd19274,
        15'd19696, 15'd20127, 15'd20568, 15'd21018, 15'd21478, 15'd21949, 15'd22429, 15'd22920,
        15'd23422, 15'd23935, 15'd24459, 15'd24995, 15'd25542, 15'd26102, 15'd26673, 15'd27257,
        15'd27854, 15'd28464, 15'd29087, 15'd29724, 15'd30375, 15'd31040, 15'd31720, 15'd32415
    };

    typedef struct packed {
        logic op;
        logic sat_zero;
        logic sat_one;
    } t_ctl;

endpackage

### rtl/fpse_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the fixed-point exp2 and sigmoid core.
// Depends on fpse_pkg for the field widths.
interface fpse_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [fpse_pkg::OPND_W-1:0] operand;

    modport source (output valid, output operation, output operand, input ready);
    modport sink (input valid, input operation, input operand, output ready);
endinterface

interface fpse_out_if;
    logic                        valid;
    logic                        ready;
    logic [fpse_pkg::RES_W-1:0]  result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

### rtl/fpse_div_step.sv
`timescale 1ns / 1ps
// One registered step of the restoring divider that forms the sigmoid quotient.
// Depends on fpse_pkg for widths and the control struct.
module fpse_div_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  fpse_pkg::t_ctl                 i_ctl,
    input  logic [fpse_pkg::RES_W-1:0]     i_pow,
    input  logic [fpse_pkg::DEN_W-1:0]     i_den,
    input  logic [fpse_pkg::DEN_W-1:0]     i_rem,
    input  logic [fpse_pkg::DIV_N-1:0]     i_quo,
    output logic                           o_vld,
    output fpse_pkg::t_ctl                 o_ctl,
    output logic [fpse_pkg::RES_W-1:0]     o_pow,
    output logic [fpse_pkg::DEN_W-1:0]     o_den,
    output logic [fpse_pkg::DEN_W-1:0]     o_rem,
    output logic [fpse_pkg::DIV_N-1:0]     o_quo
);
    logic [fpse_pkg::DEN_W:0]   w_trial;
    logic [fpse_pkg::DEN_W:0]   w_diff;
    logic                       w_bit;
    logic [fpse_pkg::DEN_W-1:0] n_rem;
    logic                       r_vld;
    fpse_pkg::t_ctl             r_ctl;
    logic [fpse_pkg::RES_W-1:0] r_pow;
    logic [fpse_pkg::DEN_W-1:0] r_den;
    logic [fpse_pkg::DEN_W-1:0] r_rem;
    logic [fpse_pkg::DIV_N-1:0] r_quo;

    always_comb begin
        w_trial = {i_rem, 1'b0};
        w_diff  = w_trial - {1'b0, i_den};
        w_bit   = (w_trial >= {1'b0, i_den});
        n_rem   = w_bit ? w_diff[fpse_pkg::DEN_W-1:0] : w_trial[fpse_pkg::DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_pow <= i_pow;
            r_den <= i_den;
            r_rem <= n_rem;
            r_quo <= {i_quo[fpse_pkg::DIV_N-2:0], w_bit};
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;
    assign o_pow = r_pow;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule

### rtl/fixed_point_sigmoid_exp2_core.sv
`timescale 1ns / 1ps
// Top level of the fixed-point base-two exponential and sigmoid core.
// Depends on fpse_pkg, the fpse_in_if and fpse_out_if interfaces and fpse_div_step.
//
// Usage: each request on i_req carries an operation and a signed 32-bit operand.
// Operation OP_EXP2 reads the operand as Q8.24 and returns 2^x in Q16.16;
// operation OP_SIGMOID reads it as Q22.10 and returns the logistic function in
// Q22.10 (0 to 1024). Every request yields exactly one result on o_res, in order.
// The datapath is a 15-stage pipeline: an argument stage with the log2(e)
// multiply, a table stage, a shift stage, eleven restoring-divider steps (one
// quotient bit each) and the output register. One request is accepted every
// cycle while i_req.ready is high.
// When the receiver stalls, results pile up in the pipeline; empty stages still
// close up, so i_req.ready only falls once every stage holds a request.
// Synchronous reset clears all stage valid bits; data registers are not reset.
module fixed_point_sigmoid_exp2_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fpse_in_if.sink      i_req,
    fpse_out_if.source   o_res
);
    logic [fpse_pkg::STG_N-1:0] w_vld;
    logic [fpse_pkg::STG_N-1:0] w_adv;

    // Argument stage.
    logic [13:0]                         w_neg;
    logic signed [25:0]                  w_prod;
    logic signed [fpse_pkg::OPND_W-1:0]  w_arg;
    fpse_pkg::t_ctl                      n_a_ctl;
    logic                                r_a_vld;
    fpse_pkg::t_ctl                      r_a_ctl;
    logic signed [fpse_pkg::OPND_W-1:0]  r_a_x;

    // Table stage.
    logic                                r_b_vld;
    fpse_pkg::t_ctl                      r_b_ctl;
    logic                                r_b_lo;
    logic                                r_b_hi;
    logic                                r_b_fz;
    logic [4:0]                          r_b_n;
    logic [fpse_pkg::LUT_W-1:0]          r_b_lut;

    // Shift stage.
    logic signed [5:0]                   w_sh;
    logic [5:0]                          w_rsh;
    logic [fpse_pkg::RES_W-1:0]          w_lut_ext;
    logic [fpse_pkg::RES_W-1:0]          n_c_pow;
    logic [fpse_pkg::DEN_W-1:0]          n_c_den;
    logic                                r_c_vld;
    fpse_pkg::t_ctl                      r_c_ctl;
    logic [fpse_pkg::RES_W-1:0]          r_c_pow;
    logic [fpse_pkg::DEN_W-1:0]          r_c_den;

    // Divider chain, entry 0 fed by the shift stage.
    logic                                w_dv_vld [fpse_pkg::DIV_N+1];
    fpse_pkg::t_ctl                      w_dv_ctl [fpse_pkg::DIV_N+1];
    logic [fpse_pkg::RES_W-1:0]          w_dv_pow [fpse_pkg::DIV_N+1];
    logic [fpse_pkg::DEN_W-1:0]          w_dv_den [fpse_pkg::DIV_N+1];
    logic [fpse_pkg::DEN_W-1:0]          w_dv_rem [fpse_pkg::DIV_N+1];
    logic [fpse_pkg::DIV_N-1:0]          w_dv_quo [fpse_pkg::DIV_N+1];

    // Output stage.
    fpse_pkg::t_ctl                      w_o_ctl;
    logic [fpse_pkg::RES_W-1:0]          n_o_res;
    logic                                r_o_vld;
    logic [fpse_pkg::RES_W-1:0]          r_o_res;

    // A stage moves when the receiver is ready or it or any stage after it is empty.
    always_comb begin
        w_vld[0] = r_a_vld;
        w_vld[1] = r_b_vld;
        w_vld[2] = r_c_vld;
        for (int j = 0; j < fpse_pkg::DIV_N; j++) begin
            w_vld[3 + j] = w_dv_vld[j + 1];
        end
        w_vld[fpse_pkg::STG_N-1] = r_o_vld;
        for (int k = 0; k < fpse_pkg::STG_N; k++) begin
            w_adv[k] = o_res.ready ||
                ((w_vld | ((fpse_pkg::STG_N'(1) << k) - fpse_pkg::STG_N'(1))) != '1);
        end
    end

    assign i_req.ready = w_adv[0];

    always_comb begin
        w_neg  = 14'(~i_req.operand[13:0]) + 14'd1;
        w_prod = $signed({{12{w_neg[13]}}, w_neg}) * fpse_pkg::ARG_MUL;
        w_arg  = {{2{w_prod[25]}}, w_prod[25:0], 4'b0000};
        n_a_ctl.op       = i_req.operation;
        n_a_ctl.sat_zero = (i_req.operand <= fpse_pkg::SIG_LIM_NEG);
        n_a_ctl.sat_one  = (i_req.operand >= fpse_pkg::SIG_LIM_POS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_adv[0]) begin
                r_a_vld <= i_req.valid;
            end
            if (w_adv[1]) begin
                r_b_vld <= r_a_vld;
            end
            if (w_adv[2]) begin
                r_c_vld <= r_b_vld;
            end
            if (w_adv[fpse_pkg::STG_N-1]) begin
                r_o_vld <= w_dv_vld[fpse_pkg::DIV_N];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_ctl <= n_a_ctl;
            r_a_x   <= (i_req.operation == fpse_pkg::OP_SIGMOID) ? w_arg : i_req.operand;
        end
        if (w_adv[1]) begin
            r_b_ctl <= r_a_ctl;
            r_b_lo  <= (r_a_x <= fpse_pkg::EXP_LO);
            r_b_hi  <= (r_a_x >= fpse_pkg::EXP_HI);
            r_b_fz  <= (r_a_x[23:0] == 24'd0);
            r_b_n   <= r_a_x[28:24];
            r_b_lut <= fpse_pkg::FRAC_LUT[r_a_x[23:19]];
        end
        if (w_adv[2]) begin
            r_c_ctl <= r_b_ctl;
            r_c_pow <= n_c_pow;
            r_c_den <= n_c_den;
        end
        if (w_adv[fpse_pkg::STG_N-1]) begin
            r_o_res <= n_o_res;
        end
    end

    always_comb begin
        w_sh      = $signed({r_b_n[4], r_b_n}) + 6'sd2;
        w_rsh     = 6'(-w_sh);
        w_lut_ext = {{(fpse_pkg::RES_W - fpse_pkg::LUT_W){1'b0}}, r_b_lut};
        if (r_b_lo) begin
            n_c_pow = fpse_pkg::POW_MIN;
        end else if (r_b_hi) begin
            n_c_pow = fpse_pkg::POW_MAX;
        end else if (r_b_fz) begin
            n_c_pow = fpse_pkg::RES_W'(1) << {~r_b_n[4], r_b_n[3:0]};
        end else if (!w_sh[5]) begin
            n_c_pow = w_lut_ext << w_sh[4:0];
        end else begin
            n_c_pow = w_lut_ext >> w_rsh[3:0];
        end
        n_c_den = fpse_pkg::DEN_W'(n_c_pow[fpse_pkg::RES_W-1:6]) + fpse_pkg::DEN_BIAS;
    end

    assign w_dv_vld[0] = r_c_vld;
    assign w_dv_ctl[0] = r_c_ctl;
    assign w_dv_pow[0] = r_c_pow;
    assign w_dv_den[0] = r_c_den;
    assign w_dv_rem[0] = fpse_pkg::REM_INIT;
    assign w_dv_quo[0] = '0;

    for (genvar g = 0; g < fpse_pkg::DIV_N; g++) begin : g_div
        fpse_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv[3 + g]),
            .i_vld   (w_dv_vld[g]),
            .i_ctl   (w_dv_ctl[g]),
            .i_pow   (w_dv_pow[g]),
            .i_den   (w_dv_den[g]),
            .i_rem   (w_dv_rem[g]),
            .i_quo   (w_dv_quo[g]),
            .o_vld   (w_dv_vld[g + 1]),
            .o_ctl   (w_dv_ctl[g + 1]),
            .o_pow   (w_dv_pow[g + 1]),
            .o_den   (w_dv_den[g + 1]),
            .o_rem   (w_dv_rem[g + 1]),
            .o_quo   (w_dv_quo[g + 1])
        );
    end

    always_comb begin
        w_o_ctl = w_dv_ctl[fpse_pkg::DIV_N];
        if (w_o_ctl.op == fpse_pkg::OP_EXP2) begin
            n_o_res = w_dv_pow[fpse_pkg::DIV_N];
        end else if (w_o_ctl.sat_zero) begin
            n_o_res = '0;
        end else if (w_o_ctl.sat_one) begin
            n_o_res = fpse_pkg::SIG_ONE;
        end else begin
            n_o_res = fpse_pkg::RES_W'(w_dv_quo[fpse_pkg::DIV_N]);
        end
    end

    assign o_res.valid  = r_o_vld;
    assign o_res.result = r_o_res;
endmodule

### rtl/fpse_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the fixed-point exp2 and sigmoid core, bound to its top level.
// Depends on fpse_pkg for the result width.
module fpse_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [fpse_pkg::RES_W-1:0]  i_out_result
);
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_free_out_takes_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("request refused while the receiver takes results");

    a_empty_out_takes_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused while no result is waiting");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_result)))
        else $error("stalled result changed or vanished");
endmodule

bind fixed_point_sigmoid_exp2_core fpse_checker u_fpse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_result (o_res.result)
);

### bench/fpse_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the fixed-point exp2 and sigmoid core: predicts each accepted request
// and compares the results in order. Depends on fpse_pkg and the fpse_in_if/fpse_out_if interfaces.
module fpse_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fpse_in_if   i_req,
    fpse_out_if  i_res,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam logic [14:0] FRAC_TABLE [32] = '{
        15'd16562, 15'd16925, 15'd17295, 15'd17674, 15'd18061, 15'd18456, 15'd18861, 15'd19274,
        15'd19696, 15'd20127, 15'd20568, 15'd21018, 15'd21478, 15'd21949, 15'd22429, 15'd22920,
        15'd23422, 15'd23935, 15'd24459, 15'd24995, 15'd25542, 15'd26102, 15'd26673, 15'd27257,
        15'd27854, 15'd28464, 15'd29087, 15'd29724, 15'd30375, 15'd31040, 15'd31720, 15'd32415
    };

    logic [30:0] expected_results [$];
    int          fail_count = 0;
    int          outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic logic [31:0] exp2_q16(input logic signed [31:0] x);
        logic signed [7:0] whole;
        logic [14:0]       mant;
        int                sh;
        if (x <= -32'sd268435456) return 32'd1;
        if (x >= 32'sd251658240) return 32'h7fff_ffff;
        whole = x[31:24];
        if (x[23:0] == 24'd0) return 32'd1 << (whole + 16);
        mant = FRAC_TABLE[x[23:19]];
        sh = whole + 2;
        if (sh >= 0) return {17'd0, mant} << sh;
        return {17'd0, mant} >> (-sh);
    endfunction

    function automatic logic [31:0] sigmoid_q10(input logic signed [31:0] v);
        logic signed [31:0] neg;
        logic signed [31:0] arg;
        logic [31:0]        e;
        neg = (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
        if (neg >= 32'sd7168) return 32'd0;
        if (neg <= -32'sd7168) return 32'd1024;
        arg = neg * 32'sd1477 * 32'sd16;
        e = exp2_q16(arg) >> 6;
        return 32'd1048576 / (e + 32'd1024);
    endfunction

    function automatic logic [30:0] predict_activation(input logic op,
                                                       input logic signed [31:0] x);
        logic [31:0] r;
        if (op == fpse_pkg::OP_EXP2) begin
            r = exp2_q16(x);
        end else begin
            r = sigmoid_q10(x);
        end
        return r[30:0];
    endfunction

    always @(posedge i_clk) begin
        logic [30:0] want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(predict_activation(i_req.operation, i_req.operand));
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0d",
                             $time, i_res.result);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.result !== want) begin
                        $display("%0t: result mismatch, expected %0d actual %0d",
                                 $time, want, i_res.result);
                        fail_count++;
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

### bench/fixed_point_sigmoid_exp2_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the fixed-point exp2 and sigmoid core: drives requests, throttles results
// and gives the verdict. Depends on fpse_pkg, the channel interfaces and fpse_result_checker.
module fixed_point_sigmoid_exp2_core_tb;

    localparam int CYCLE_LIMIT = 300000;

    localparam logic signed [31:0] EXP2_CORNERS [12] = '{
        32'shF000_0000, 32'shF000_0001, 32'shF100_0000, 32'sh0F00_0000,
        32'sh0EFF_FFFF, 32'sh0000_0000, 32'sh0100_0000, 32'sh7FFF_FFFF,
        32'sh8000_0001, 32'sh00F8_0000, 32'shFF08_0000, 32'sh0040_0001
    };
    localparam logic signed [31:0] SIGMOID_CORNERS [12] = '{
        32'sd0, 32'sd7168, -32'sd7168, 32'sd7167, -32'sd7167, 32'sd7169,
        -32'sd7169, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0001, 32'sd1024
    };

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   outstanding;
    bit   calm = 1'b1;
    bit   backlog_req = 1'b0;
    int   stall_left = 0;

    fpse_in_if  req_ch ();
    fpse_out_if res_ch ();

    fixed_point_sigmoid_exp2_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    fpse_result_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_request(input logic op, input logic signed [31:0] val);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.operand   <= val;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic draw_request(output logic op, output logic signed [31:0] val);
        op = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: val = $urandom;
            1: begin
                if (op == fpse_pkg::OP_EXP2) begin
                    val = (int'($urandom_range(0, 31)) - 16) <<< 24;
                end else begin
                    val = (($urandom_range(0, 1) == 0) ? 7168 : -7168)
                          + int'($urandom_range(0, 4)) - 2;
                end
            end
            default: begin
                if (op == fpse_pkg::OP_EXP2) begin
                    val = int'($urandom_range(0, 33 * 2 ** 24)) - 17 * 2 ** 24;
                end else begin
                    val = int'($urandom_range(0, 16000)) - 8000;
                end
            end
        endcase
        if (val == 32'sh8000_0000) val = 32'sh8000_0001;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (backlog_req) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                backlog_req = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic              op;
        logic signed [31:0] val;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= fpse_pkg::OP_EXP2;
        req_ch.operand   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 12; i++) begin
            calm = (i < 6);
            push_request(fpse_pkg::OP_EXP2, EXP2_CORNERS[i]);
            push_request(fpse_pkg::OP_SIGMOID, SIGMOID_CORNERS[i]);
        end

        calm = 1'b0;
        for (int i = 0; i < 350; i++) begin
            draw_request(op, val);
            push_request(op, val);
        end

        req_ch.valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // The receiver holds off while requests keep coming, so the pipeline fills and stalls.
        calm = 1'b1;
        backlog_req = 1'b1;
        for (int i = 0; i < 60; i++) begin
            draw_request(op, val);
            push_request(op, val);
        end

        for (int i = 0; i < 620; i++) begin
            if (i % 80 == 0) calm = ($urandom_range(0, 2) == 0);
            draw_request(op, val);
            push_request(op, val);
        end

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/fpse_pkg.sv
rtl/fpse_if.sv
rtl/fpse_div_step.sv
rtl/fixed_point_sigmoid_exp2_core.sv
rtl/fpse_checker.sv
bench/fpse_result_checker.sv
bench/fixed_point_sigmoid_exp2_core_tb.sv
